// ===== src/nfa_pkg.sv =====
// shared types, constants and sequencer states of the next-fit allocator
`timescale 1ns / 1ps
`default_nettype none
package nfa_pkg;

    localparam int ARENA_UNITS = 4096;
    localparam int UNIT_BYTES  = 8;
    localparam int ADDR_W      = $clog2(ARENA_UNITS);
    localparam int SIZE_W      = ADDR_W + 1;
    localparam int SUM_W       = SIZE_W + 1;
    localparam int BYTES_W     = 15;
    localparam int UNIT_SHIFT  = $clog2(UNIT_BYTES);
    localparam int STEP_W      = ADDR_W + 1;

    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [SIZE_W-1:0] t_size;

    localparam t_size ARENA_SIZE = t_size'(ARENA_UNITS);
    localparam logic [STEP_W-1:0] STEP_MAX = STEP_W'(ARENA_UNITS);

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_A_HEAD,
        ST_A_SCAN,
        ST_A_TAIL,
        ST_F_SCAN,
        ST_F_RDBP,
        ST_F_RDNX,
        ST_F_RDP,
        ST_F_LOWER,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic  we;
        t_addr waddr;
        t_addr wdata;
        t_addr raddr;
    } t_link_req;

    typedef struct packed {
        logic  we;
        t_addr waddr;
        t_size wdata;
        t_addr raddr;
    } t_size_req;

    // saturating size add, clipped at the arena size
    function automatic t_size sat_add(t_size a, t_size b);
        logic [SUM_W-1:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s > SUM_W'(ARENA_UNITS)) ? ARENA_SIZE : s[SIZE_W-1:0];
    endfunction

endpackage
`default_nettype wire

// ===== src/nfa_ram.sv =====
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps
`default_nettype none
module nfa_ram #(
    parameter int DATA_W = 12,
    parameter int ADDR_W = 12
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [DATA_W-1:0] i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [2**ADDR_W];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// ===== src/nfa_seq.sv =====
// list walk sequencer: one header read and one compare step per cycle
`timescale 1ns / 1ps
`default_nettype none
module nfa_seq import nfa_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic               i_op,
    input  wire logic [BYTES_W-1:0] i_bytes,
    input  wire t_addr              i_free_addr,
    input  wire logic               i_take,
    output logic                    o_idle,
    output logic                    o_done,
    output t_addr                   o_addr,
    output logic                    o_fail,
    output t_link_req               o_link_req,
    output t_size_req               o_size_req,
    input  wire t_addr              i_link_rdata,
    input  wire t_size              i_size_rdata
);

    t_state r_state, n_state;
    t_addr  r_rover, n_rover;
    t_addr  r_prev, n_prev;
    t_addr  r_p, n_p;
    t_addr  r_q, n_q;
    t_addr  r_bp, n_bp;
    t_addr  r_nx, n_nx;
    t_size  r_need, n_need;
    t_size  r_szbp, n_szbp;
    t_size  r_sznx, n_sznx;
    t_size  r_szp, n_szp;
    t_size  r_newsz, n_newsz;
    t_addr  r_lnknx, n_lnknx;
    t_addr  r_newlnk, n_newlnk;
    t_addr  r_addr, n_addr;
    logic   r_fail, n_fail;
    logic   r_force, n_force;
    logic [STEP_W-1:0] r_steps, n_steps;

    // entry zero holds the whole arena until first written
    logic   r_l0_w, r_s0_w, r_lrd_rst, r_srd_rst;
    t_addr  lrd;
    t_size  srd;

    logic             fit, exact, brk, up_merge, lo_merge;
    t_size            cut;
    logic [SUM_W-1:0] up_sum, lo_sum;

    assign lrd = r_lrd_rst ? '0 : i_link_rdata;
    assign srd = r_srd_rst ? ARENA_SIZE : i_size_rdata;

    assign fit      = srd >= r_need;
    assign exact    = srd == r_need;
    assign cut      = srd - r_need;
    assign brk      = r_force || (r_bp > r_p && r_bp < lrd)
                      || (r_p >= lrd && (r_bp > r_p || r_bp < lrd));
    assign up_sum   = SUM_W'(r_bp) + SUM_W'(r_szbp);
    assign up_merge = up_sum == SUM_W'(r_nx);
    assign lo_sum   = SUM_W'(r_p) + SUM_W'(r_szp);
    assign lo_merge = lo_sum == SUM_W'(r_bp);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:    if (i_start) n_state = (i_op == OP_FREE) ? ST_F_SCAN : ST_A_HEAD;
            ST_A_HEAD:  n_state = ST_A_SCAN;
            ST_A_SCAN: begin
                if (fit) begin
                    if (exact) n_state = ST_DONE;
                    else       n_state = ST_A_TAIL;
                end else if (r_p == r_rover || r_steps == STEP_MAX) begin
                    n_state = ST_DONE;
                end
            end
            ST_A_TAIL:  n_state = ST_DONE;
            ST_F_SCAN:  if (brk) n_state = ST_F_RDBP;
            ST_F_RDBP:  n_state = ST_F_RDNX;
            ST_F_RDNX:  n_state = ST_F_RDP;
            ST_F_RDP:   n_state = ST_F_LOWER;
            ST_F_LOWER: n_state = ST_DONE;
            ST_DONE:    if (i_take) n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    // datapath and memory requests
    always_comb begin
        n_rover  = r_rover;
        n_prev   = r_prev;
        n_p      = r_p;
        n_q      = r_q;
        n_bp     = r_bp;
        n_nx     = r_nx;
        n_need   = r_need;
        n_szbp   = r_szbp;
        n_sznx   = r_sznx;
        n_szp    = r_szp;
        n_newsz  = r_newsz;
        n_lnknx  = r_lnknx;
        n_newlnk = r_newlnk;
        n_addr   = r_addr;
        n_fail   = r_fail;
        n_force  = r_force;
        n_steps  = r_steps;
        o_link_req = '{we: 1'b0, waddr: r_p, wdata: r_nx, raddr: r_p};
        o_size_req = '{we: 1'b0, waddr: r_p, wdata: r_need, raddr: r_p};
        unique case (r_state)
            ST_IDLE: begin
                o_link_req.raddr = r_rover;
                n_prev  = r_rover;
                n_p     = r_rover;
                n_steps = '0;
                n_force = 1'b0;
                n_addr  = '0;
                n_fail  = 1'b0;
                n_need  = t_size'(({1'b0, i_bytes} + 16'(UNIT_BYTES - 1)) >> UNIT_SHIFT) + 1'b1;
                n_bp    = i_free_addr - 1'b1;
            end
            ST_A_HEAD: begin
                n_p = lrd;
                o_link_req.raddr = lrd;
                o_size_req.raddr = lrd;
            end
            ST_A_SCAN: begin
                if (fit) begin
                    if (exact) begin
                        if (lrd == r_p) begin
                            n_fail = 1'b1;
                        end else begin
                            o_link_req.we    = 1'b1;
                            o_link_req.waddr = r_prev;
                            o_link_req.wdata = lrd;
                            n_addr  = r_p + 1'b1;
                            n_rover = r_prev;
                        end
                    end else begin
                        o_size_req.we    = 1'b1;
                        o_size_req.waddr = r_p;
                        o_size_req.wdata = cut;
                        n_q     = r_p + cut[ADDR_W-1:0];
                        n_addr  = r_p + cut[ADDR_W-1:0] + 1'b1;
                        n_rover = r_prev;
                    end
                end else if (r_p == r_rover || r_steps == STEP_MAX) begin
                    n_fail = 1'b1;
                end else begin
                    n_steps = r_steps + 1'b1;
                    n_prev  = r_p;
                    n_p     = lrd;
                    o_link_req.raddr = lrd;
                    o_size_req.raddr = lrd;
                end
            end
            ST_A_TAIL: begin
                o_size_req.we    = 1'b1;
                o_size_req.waddr = r_q;
                o_size_req.wdata = r_need;
            end
            ST_F_SCAN: begin
                if (brk) begin
                    n_nx = lrd;
                    o_size_req.raddr = r_bp;
                    o_link_req.raddr = lrd;
                end else begin
                    if (r_steps == STEP_MAX) n_force = 1'b1;
                    n_steps = r_steps + 1'b1;
                    n_p     = lrd;
                    o_link_req.raddr = lrd;
                end
            end
            ST_F_RDBP: begin
                n_szbp  = srd;
                n_lnknx = lrd;
                o_size_req.raddr = r_nx;
            end
            ST_F_RDNX: begin
                n_sznx = srd;
                o_size_req.raddr = r_p;
            end
            ST_F_RDP: begin
                n_newsz  = up_merge ? sat_add(r_szbp, r_sznx) : r_szbp;
                n_newlnk = up_merge ? r_lnknx : r_nx;
                n_szp    = (r_p == r_bp) ? n_newsz : srd;
                o_link_req.we    = 1'b1;
                o_link_req.waddr = r_bp;
                o_link_req.wdata = n_newlnk;
                o_size_req.we    = 1'b1;
                o_size_req.waddr = r_bp;
                o_size_req.wdata = n_newsz;
            end
            ST_F_LOWER: begin
                o_link_req.we    = 1'b1;
                o_link_req.waddr = r_p;
                o_link_req.wdata = lo_merge ? r_newlnk : r_bp;
                o_size_req.we    = lo_merge;
                o_size_req.waddr = r_p;
                o_size_req.wdata = sat_add(r_szp, r_newsz);
                n_rover = r_p;
            end
            ST_DONE: begin
            end
            default: begin
            end
        endcase
    end

    // outputs
    always_comb begin
        o_idle = r_state == ST_IDLE;
        o_done = r_state == ST_DONE;
        o_addr = r_addr;
        o_fail = r_fail;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_rover   <= '0;
            r_l0_w    <= 1'b0;
            r_s0_w    <= 1'b0;
            r_lrd_rst <= 1'b0;
            r_srd_rst <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rover   <= n_rover;
            r_lrd_rst <= (o_link_req.raddr == '0) && !r_l0_w;
            r_srd_rst <= (o_size_req.raddr == '0) && !r_s0_w;
            if (o_link_req.we && o_link_req.waddr == '0) r_l0_w <= 1'b1;
            if (o_size_req.we && o_size_req.waddr == '0) r_s0_w <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prev   <= n_prev;
        r_p      <= n_p;
        r_q      <= n_q;
        r_bp     <= n_bp;
        r_nx     <= n_nx;
        r_need   <= n_need;
        r_szbp   <= n_szbp;
        r_sznx   <= n_sznx;
        r_szp    <= n_szp;
        r_newsz  <= n_newsz;
        r_lnknx  <= n_lnknx;
        r_newlnk <= n_newlnk;
        r_addr   <= n_addr;
        r_fail   <= n_fail;
        r_force  <= n_force;
        r_steps  <= n_steps;
    end

endmodule
`default_nettype wire

// ===== src/next_fit_free_list_allocator.sv =====
// top level of the next-fit free-list allocator
//
//  channel  direction  tdata (low bit first)                      tuser
//  s_axis   in         request_bytes[14:0], free_addr[26:15], pad  op (0 alloc, 1 free)
//  m_axis   out        block_addr[11:0], pad                      failed
//
// an allocation visits free blocks in turn from the rover and writes a tail
// size when it splits one; a free passes blocks to find its place, then
// merges. the bound is the list walk: one header read from the link and size
// rams per cycle. the result sits in an output register; the sequencer holds
// in its done state while that register is still full. no clearing pass
// after reset: entry zero reads as the whole arena until first written.
`timescale 1ns / 1ps
`default_nettype none
module next_fit_free_list_allocator import nfa_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // request_bytes, free_addr
    input  wire logic        s_axis_tuser,   // op
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // block_addr
    output logic             m_axis_tuser    // failed
);

    logic      idle, done, fail, take;
    t_addr     addr, lrd_raw;
    t_size     srd_raw;
    t_link_req link_req;
    t_size_req size_req;
    logic      r_ovalid;
    t_addr     r_oaddr;
    logic      r_ofail;

    assign s_axis_tready = idle;
    // result moves to the output register once it is free
    assign take          = done && (!r_ovalid || m_axis_tready);

    nfa_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (s_axis_tvalid && idle),
        .i_op         (s_axis_tuser),
        .i_bytes      (s_axis_tdata[BYTES_W-1:0]),
        .i_free_addr  (s_axis_tdata[BYTES_W+ADDR_W-1:BYTES_W]),
        .i_take       (take),
        .o_idle       (idle),
        .o_done       (done),
        .o_addr       (addr),
        .o_fail       (fail),
        .o_link_req   (link_req),
        .o_size_req   (size_req),
        .i_link_rdata (lrd_raw),
        .i_size_rdata (srd_raw)
    );

    // next links of free block headers
    nfa_ram #(.DATA_W(ADDR_W), .ADDR_W(ADDR_W)) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (link_req.we),
        .i_waddr (link_req.waddr),
        .i_wdata (link_req.wdata),
        .i_raddr (link_req.raddr),
        .o_rdata (lrd_raw)
    );

    // block sizes in units
    nfa_ram #(.DATA_W(SIZE_W), .ADDR_W(ADDR_W)) u_size_ram (
        .i_clk   (i_clk),
        .i_we    (size_req.we),
        .i_waddr (size_req.waddr),
        .i_wdata (size_req.wdata),
        .i_raddr (size_req.raddr),
        .o_rdata (srd_raw)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (take) begin
            r_ovalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_oaddr <= addr;
            r_ofail <= fail;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {{(16 - ADDR_W){1'b0}}, r_oaddr};
    assign m_axis_tuser  = r_ofail;

endmodule
`default_nettype wire

// ===== sim/next_fit_free_list_allocator_tb.sv =====
// testbench of the next-fit free-list allocator: directed and random allocations and frees
`timescale 1ns / 1ps
`default_nettype none
module next_fit_free_list_allocator_tb;
    import nfa_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;   // request_bytes[14:0], free_addr[26:15], zero pad
    logic        s_axis_tuser;   // op
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;   // block_addr[11:0], zero pad
    logic        m_axis_tuser;   // failed

    next_fit_free_list_allocator dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
    );

    typedef struct {
        t_addr block_addr;
        logic  failed;
    } t_result;

    // own copy of the free list
    int unsigned next_link[ARENA_UNITS];
    int unsigned unit_count[ARENA_UNITS];
    int unsigned rover;

    t_result pending_results[$];
    t_addr   live_blocks[$];     // payload units currently handed out
    int      errors = 0;
    int      sender_idle = 0;    // percent
    int      receiver_idle = 0;  // percent
    int      hold_cycles = 0;    // receiver hold-off still to run

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("== FAIL ==");
        $finish;
    end

    function automatic int unsigned grow(int unsigned a, int unsigned b);
        return (a + b > ARENA_UNITS) ? ARENA_UNITS : a + b;
    endfunction

    // next-fit search from the block after the rover
    function automatic t_result carve_block(int unsigned nbytes);
        t_result     r;
        int unsigned need, prev, p, q;
        need = (nbytes + UNIT_BYTES - 1) / UNIT_BYTES + 1;
        prev = rover % ARENA_UNITS;
        p = next_link[prev] % ARENA_UNITS;
        r.block_addr = '0;
        r.failed = 1'b1;
        for (int steps = 0; steps <= ARENA_UNITS; steps++) begin
            if (unit_count[p] >= need) begin
                if (unit_count[p] == need) begin
                    // last free block taken whole: refused
                    if (next_link[p] % ARENA_UNITS == p) return r;
                    next_link[prev] = next_link[p] % ARENA_UNITS;
                    q = p;
                end else begin
                    unit_count[p] = unit_count[p] - need;
                    q = (p + unit_count[p]) % ARENA_UNITS;
                    unit_count[q] = need;
                end
                rover = prev;
                r.block_addr = t_addr'(q + 1);
                r.failed = 1'b0;
                return r;
            end
            if (p == rover) return r;
            prev = p;
            p = next_link[p] % ARENA_UNITS;
        end
        return r;
    endfunction

    // address-ordered insert with merge on both sides
    function automatic void return_block(t_addr payload);
        int unsigned bp, p, nx;
        bp = (payload + ARENA_UNITS - 1) % ARENA_UNITS;
        p = rover % ARENA_UNITS;
        for (int steps = 0; steps <= ARENA_UNITS; steps++) begin
            nx = next_link[p] % ARENA_UNITS;
            if (bp > p && bp < nx) break;
            if (p >= nx && (bp > p || bp < nx)) break;
            p = nx;
        end
        nx = next_link[p] % ARENA_UNITS;
        if (bp + unit_count[bp] == nx) begin
            unit_count[bp] = grow(unit_count[bp], unit_count[nx]);
            next_link[bp] = next_link[nx] % ARENA_UNITS;
        end else begin
            next_link[bp] = nx;
        end
        if (p + unit_count[p] == bp) begin
            unit_count[p] = grow(unit_count[p], unit_count[bp]);
            next_link[p] = next_link[bp] % ARENA_UNITS;
        end else begin
            next_link[p] = bp;
        end
        rover = p;
    endfunction

    // offer one transaction, keep tvalid high after it is taken
    task automatic send_request(logic op, logic [14:0] nbytes, t_addr payload);
        t_result r;
        if ($urandom_range(99) < sender_idle) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {5'b0, payload, nbytes};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        if (op == OP_ALLOC) begin
            r = carve_block(nbytes);
            if (!r.failed) live_blocks.push_back(r.block_addr);
        end else begin
            return_block(payload);
            r.block_addr = '0;
            r.failed = 1'b0;
        end
        pending_results.push_back(r);
    endtask

    task automatic send_alloc(int unsigned nbytes);
        send_request(OP_ALLOC, nbytes[14:0], t_addr'($urandom));
    endtask

    task automatic send_free_random();
        int    k;
        t_addr a;
        k = $urandom_range(live_blocks.size() - 1);
        a = live_blocks[k];
        live_blocks.delete(k);
        send_request(OP_FREE, 15'($urandom), a);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // receiver ready, with random stalls and a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= receiver_idle);
        end
    end

    // result checker against the oldest expectation
    always @(posedge i_clk) begin
        t_result e;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result addr=%0d failed=%0b", $time,
                         m_axis_tdata[11:0], m_axis_tuser);
                errors++;
            end else begin
                e = pending_results.pop_front();
                if (m_axis_tdata[11:0] !== e.block_addr) begin
                    $display("%0t: block_addr expected %0d actual %0d", $time,
                             e.block_addr, m_axis_tdata[11:0]);
                    errors++;
                end
                if (m_axis_tuser !== e.failed) begin
                    $display("%0t: failed expected %0b actual %0b", $time,
                             e.failed, m_axis_tuser);
                    errors++;
                end
            end
        end
    end

    // extremes, zero bytes, refused whole-block take, exhaustion
    task automatic test_directed();
        send_alloc(32767);   // needs more than the arena
        send_alloc(32760);   // would take the only block whole
        send_alloc(0);       // header unit only, payload wraps to zero
        send_alloc(1);
        send_alloc(8);
        send_alloc(9);
        send_alloc(16000);
        send_alloc(16000);   // still fits in what is left
        send_free_random();
        send_free_random();
        send_alloc(100);
        while (live_blocks.size() > 0) send_free_random();
        send_alloc(2047);
        send_alloc(4095);
        send_alloc(255);
        wait_drained();
    endtask

    task automatic test_random(int count);
        for (int i = 0; i < count; i++) begin
            if (live_blocks.size() == 0 || $urandom_range(99) < 55) begin
                case ($urandom_range(9))
                    0:       send_alloc($urandom_range(32767));
                    1:       send_alloc($urandom_range(4095));
                    default: send_alloc($urandom_range(200));
                endcase
            end else begin
                send_free_random();
            end
        end
        wait_drained();
    endtask

    // receiver held off while requests pile up behind the output register
    task automatic test_backpressure();
        hold_cycles = 400;
        for (int i = 0; i < 20; i++) begin
            if (live_blocks.size() > 0 && i % 3 == 2) send_free_random();
            else send_alloc($urandom_range(64));
        end
        wait_drained();
    endtask

    initial begin
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = OP_ALLOC;
        m_axis_tready = 1'b0;
        next_link[0] = 0;
        unit_count[0] = ARENA_UNITS;
        rover = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        sender_idle = 22; receiver_idle = 53;
        test_directed();
        test_random(160);
        test_backpressure();
        sender_idle = 53; receiver_idle = 22;
        test_random(160);
        sender_idle = 0; receiver_idle = 0;
        test_random(160);

        repeat (50) @(posedge i_clk);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
`default_nettype wire
